FILE: design/ctt_pkg.sv
// Package with the shared types, codes and character helpers of the config text tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package ctt_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF    = 64;

  typedef enum logic [2:0] {
    LX_IDLE    = 3'd0,
    LX_COMMENT = 3'd1,
    LX_INCLUDE = 3'd2,
    LX_WORD    = 3'd3,
    LX_QUOTED  = 3'd4,
    LX_INT     = 3'd5,
    LX_DEC     = 3'd6
  } lex_state_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [1:0] KIND_ERROR     = 2'd2;
  localparam logic [1:0] KIND_EOI       = 2'd3;

  localparam logic [3:0] TT_NONE     = 4'd0;
  localparam logic [3:0] TT_LBRACE   = 4'd0;
  localparam logic [3:0] TT_RBRACE   = 4'd1;
  localparam logic [3:0] TT_LBRACKET = 4'd2;
  localparam logic [3:0] TT_RBRACKET = 4'd3;
  localparam logic [3:0] TT_LPAREN   = 4'd4;
  localparam logic [3:0] TT_RPAREN   = 4'd5;
  localparam logic [3:0] TT_WORD     = 4'd6;
  localparam logic [3:0] TT_QUOTED   = 4'd7;
  localparam logic [3:0] TT_INTEGER  = 4'd8;
  localparam logic [3:0] TT_DECIMAL  = 4'd9;
  localparam logic [3:0] TT_INCLUDE  = 4'd10;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_BAD_INT    = 3'd2;
  localparam logic [2:0] ERR_BAD_DEC    = 3'd3;
  localparam logic [2:0] ERR_FAILED     = 3'd4;

  localparam int F_NOTDEC = 0;
  localparam int F_BADINT = 1;
  localparam int F_LONG   = 2;
  localparam int F_DIGIT  = 3;
  localparam int F_DOT    = 4;
  localparam int F_BADDEC = 5;

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_X        = 8'h78;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_SEVEN    = 8'h37;
  localparam logic [7:0] CH_UNDER    = 8'h5F;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] token_type;
    logic [7:0] char_out;
    logic [2:0] error_code;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Returns the hex digit value in the low four bits and a valid flag on top.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (is_digit(c)) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage
`default_nettype wire

FILE: design/ctt_acc.sv
// Saturating constant-base multiply-add for the integer value accumulator.
`timescale 1ns / 1ps
`default_nettype none
module ctt_acc #(
  parameter int VALUE_BITS = ctt_pkg::VALUE_BITS_DEF
) (
  input  wire logic [VALUE_BITS-2:0] acc,
  input  wire ctt_pkg::base_t        base,
  input  wire logic [3:0]            digit,
  output logic      [VALUE_BITS-2:0] sum
);

  localparam int WIDE_BITS = VALUE_BITS + 3;

  logic [WIDE_BITS-1:0] ext;
  logic [WIDE_BITS-1:0] scaled;
  logic [WIDE_BITS-1:0] wide;
  logic                 over;

  assign ext = WIDE_BITS'(acc);

  always_comb begin
    case (base)
      ctt_pkg::BASE_DEC: scaled = (ext << 3) + (ext << 1);
      ctt_pkg::BASE_OCT: scaled = ext << 3;
      ctt_pkg::BASE_HEX: scaled = ext << 4;
      default:           scaled = ext << 3;
    endcase
  end

  assign wide = scaled + WIDE_BITS'(digit);
  assign over = |wide[WIDE_BITS-1:VALUE_BITS-1];
  assign sum  = over ? {(VALUE_BITS-1){1'b1}} : wide[VALUE_BITS-2:0];

endmodule
`default_nettype wire

FILE: design/ctt_lexer.sv
// Lexer state machine with position counters, spelling checks and result decode.
`timescale 1ns / 1ps
`default_nettype none
module ctt_lexer #(
  parameter int POSITION_BITS = ctt_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = ctt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     fire,
  input  wire logic [7:0]               in_byte,
  input  wire logic                     end_of_input,
  output logic                          res_valid,
  output ctt_pkg::res_t                 res,
  output logic      [VALUE_BITS-2:0]    res_value,
  output logic      [POSITION_BITS-1:0] res_line,
  output logic      [POSITION_BITS-1:0] res_col
);

  localparam logic [POSITION_BITS-1:0] PMAX = {POSITION_BITS{1'b1}};

  ctt_pkg::lex_state_t       state_r, state_nxt;
  ctt_pkg::base_t            base_r, base_nxt;
  logic [5:0]                flags_r, flags_nxt;
  logic [VALUE_BITS-2:0]     acc_r, acc_nxt;
  logic [POSITION_BITS-1:0]  line_r, line_nxt;
  logic [POSITION_BITS-1:0]  col_r, col_nxt;
  logic                      failed_r, failed_nxt;

  logic                      normal;
  logic [POSITION_BITS-1:0]  cnt_col;
  logic [POSITION_BITS-1:0]  cnt_line;
  logic [4:0]                hv;
  logic                      hex_ok;
  logic                      c_digit;
  logic                      c_alpha;
  logic                      c_space;
  logic                      c_word;
  logic [VALUE_BITS-2:0]     acc_sum;
  logic                      int_bad;
  logic                      dec_bad;

  assign normal  = !failed_r && !end_of_input;
  assign hv      = ctt_pkg::hex_value(in_byte);
  assign hex_ok  = hv[4];
  assign c_digit = ctt_pkg::is_digit(in_byte);
  assign c_alpha = ctt_pkg::is_alpha(in_byte);
  assign c_space = ctt_pkg::is_space(in_byte);
  assign c_word  = c_alpha || c_digit || (in_byte == ctt_pkg::CH_UNDER);
  assign int_bad = flags_r[ctt_pkg::F_BADINT] ||
                   ((base_r == ctt_pkg::BASE_HEX) && !flags_r[ctt_pkg::F_DIGIT]);
  assign dec_bad = flags_r[ctt_pkg::F_BADDEC] || !flags_r[ctt_pkg::F_DIGIT];

  always_comb begin
    cnt_col  = (col_r != PMAX) ? col_r + POSITION_BITS'(1) : col_r;
    cnt_line = line_r;
    if (in_byte == ctt_pkg::CH_NL) begin
      cnt_col  = '0;
      cnt_line = (line_r != PMAX) ? line_r + POSITION_BITS'(1) : line_r;
    end
  end

  assign res_line = normal ? cnt_line : line_r;
  assign res_col  = normal ? cnt_col : col_r;

  ctt_acc #(
    .VALUE_BITS(VALUE_BITS)
  ) u_acc (
    .acc  (acc_r),
    .base (base_r),
    .digit(hv[3:0]),
    .sum  (acc_sum)
  );

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    flags_nxt  = flags_r;
    acc_nxt    = acc_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    failed_nxt = failed_r;
    if (fire && !failed_r) begin
      if (end_of_input) begin
        state_nxt = ctt_pkg::LX_IDLE;
      end else begin
        line_nxt = cnt_line;
        col_nxt  = cnt_col;
        case (state_r)
          ctt_pkg::LX_IDLE: begin
            if (in_byte == ctt_pkg::CH_QUOTE) begin
              state_nxt = ctt_pkg::LX_QUOTED;
            end else if (in_byte == ctt_pkg::CH_HASH) begin
              state_nxt = ctt_pkg::LX_COMMENT;
            end else if (in_byte == ctt_pkg::CH_LT) begin
              state_nxt = ctt_pkg::LX_INCLUDE;
            end else if (c_alpha || in_byte == ctt_pkg::CH_UNDER) begin
              state_nxt = ctt_pkg::LX_WORD;
            end else if (c_digit) begin
              state_nxt = ctt_pkg::LX_INT;
              flags_nxt = '0;
              base_nxt  = (in_byte == ctt_pkg::CH_ZERO) ? ctt_pkg::BASE_OCT : ctt_pkg::BASE_DEC;
              acc_nxt   = (VALUE_BITS-1)'(hv[3:0]);
            end else if (in_byte == ctt_pkg::CH_DOT) begin
              state_nxt = ctt_pkg::LX_DEC;
              flags_nxt = 6'd1 << ctt_pkg::F_DOT;
              acc_nxt   = '0;
            end else if (in_byte == ctt_pkg::CH_LBRACE || in_byte == ctt_pkg::CH_RBRACE ||
                         in_byte == ctt_pkg::CH_LBRACKET || in_byte == ctt_pkg::CH_RBRACKET ||
                         in_byte == ctt_pkg::CH_LPAREN || in_byte == ctt_pkg::CH_RPAREN) begin
              state_nxt = ctt_pkg::LX_IDLE;
            end else if (!c_space) begin
              failed_nxt = 1'b1;
            end
          end
          ctt_pkg::LX_COMMENT: begin
            if (in_byte == ctt_pkg::CH_NL) begin
              state_nxt = ctt_pkg::LX_IDLE;
            end
          end
          ctt_pkg::LX_INCLUDE: begin
            if (in_byte == ctt_pkg::CH_GT) begin
              state_nxt = ctt_pkg::LX_IDLE;
            end
          end
          ctt_pkg::LX_QUOTED: begin
            if (in_byte == ctt_pkg::CH_QUOTE) begin
              state_nxt = ctt_pkg::LX_IDLE;
            end
          end
          ctt_pkg::LX_WORD: begin
            if (!c_word) begin
              state_nxt = ctt_pkg::LX_IDLE;
              if (!c_space) begin
                failed_nxt = 1'b1;
              end
            end
          end
          ctt_pkg::LX_INT: begin
            if (hex_ok || in_byte == ctt_pkg::CH_X) begin
              flags_nxt[ctt_pkg::F_LONG] = 1'b1;
              if (!c_digit) begin
                flags_nxt[ctt_pkg::F_NOTDEC] = 1'b1;
              end
              if (!flags_r[ctt_pkg::F_BADINT]) begin
                case (base_r)
                  ctt_pkg::BASE_DEC: begin
                    if (c_digit) begin
                      acc_nxt = acc_sum;
                    end else begin
                      flags_nxt[ctt_pkg::F_BADINT] = 1'b1;
                    end
                  end
                  ctt_pkg::BASE_OCT: begin
                    if (in_byte == ctt_pkg::CH_X && !flags_r[ctt_pkg::F_LONG]) begin
                      base_nxt = ctt_pkg::BASE_HEX;
                    end else if (in_byte >= ctt_pkg::CH_ZERO && in_byte <= ctt_pkg::CH_SEVEN) begin
                      acc_nxt = acc_sum;
                    end else begin
                      flags_nxt[ctt_pkg::F_BADINT] = 1'b1;
                    end
                  end
                  default: begin
                    if (hex_ok) begin
                      acc_nxt = acc_sum;
                      flags_nxt[ctt_pkg::F_DIGIT] = 1'b1;
                    end else begin
                      flags_nxt[ctt_pkg::F_BADINT] = 1'b1;
                    end
                  end
                endcase
              end
            end else if (in_byte == ctt_pkg::CH_DOT) begin
              if (!flags_r[ctt_pkg::F_NOTDEC]) begin
                flags_nxt = 6'd1 << ctt_pkg::F_DIGIT;
              end else if (base_r == ctt_pkg::BASE_HEX && !flags_r[ctt_pkg::F_BADINT]) begin
                flags_nxt = flags_r & (6'd1 << ctt_pkg::F_DIGIT);
              end else begin
                flags_nxt = 6'd1 << ctt_pkg::F_BADDEC;
              end
              flags_nxt[ctt_pkg::F_DOT] = 1'b1;
              state_nxt = ctt_pkg::LX_DEC;
            end else begin
              state_nxt = ctt_pkg::LX_IDLE;
              if (!c_space || int_bad) begin
                failed_nxt = 1'b1;
              end
            end
          end
          ctt_pkg::LX_DEC: begin
            if (c_digit) begin
              flags_nxt[ctt_pkg::F_DIGIT] = 1'b1;
            end else if (in_byte == ctt_pkg::CH_DOT) begin
              if (flags_r[ctt_pkg::F_DOT]) begin
                flags_nxt[ctt_pkg::F_BADDEC] = 1'b1;
              end
              flags_nxt[ctt_pkg::F_DOT] = 1'b1;
            end else begin
              state_nxt = ctt_pkg::LX_IDLE;
              if (!c_space || dec_bad) begin
                failed_nxt = 1'b1;
              end
            end
          end
          default: begin
            state_nxt = ctt_pkg::LX_IDLE;
          end
        endcase
        if (failed_nxt) begin
          state_nxt = ctt_pkg::LX_IDLE;
        end
      end
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    res_value = '0;
    if (failed_r) begin
      res_valid      = 1'b1;
      res.kind       = ctt_pkg::KIND_ERROR;
      res.error_code = ctt_pkg::ERR_FAILED;
    end else if (end_of_input) begin
      res_valid = 1'b1;
      res.kind  = ctt_pkg::KIND_EOI;
    end else begin
      case (state_r)
        ctt_pkg::LX_IDLE: begin
          if (in_byte == ctt_pkg::CH_LBRACE) begin
            res_valid      = 1'b1;
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_LBRACE;
          end else if (in_byte == ctt_pkg::CH_RBRACE) begin
            res_valid      = 1'b1;
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_RBRACE;
          end else if (in_byte == ctt_pkg::CH_LBRACKET) begin
            res_valid      = 1'b1;
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_LBRACKET;
          end else if (in_byte == ctt_pkg::CH_RBRACKET) begin
            res_valid      = 1'b1;
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_RBRACKET;
          end else if (in_byte == ctt_pkg::CH_LPAREN) begin
            res_valid      = 1'b1;
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_LPAREN;
          end else if (in_byte == ctt_pkg::CH_RPAREN) begin
            res_valid      = 1'b1;
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_RPAREN;
          end else if (in_byte == ctt_pkg::CH_QUOTE || in_byte == ctt_pkg::CH_HASH ||
                       in_byte == ctt_pkg::CH_LT) begin
            res_valid = 1'b0;
          end else if (c_word || in_byte == ctt_pkg::CH_DOT) begin
            res_valid    = 1'b1;
            res.kind     = ctt_pkg::KIND_CHAR;
            res.char_out = in_byte;
          end else if (!c_space) begin
            res_valid      = 1'b1;
            res.kind       = ctt_pkg::KIND_ERROR;
            res.error_code = ctt_pkg::ERR_UNEXPECTED;
          end
        end
        ctt_pkg::LX_COMMENT: begin
          res_valid = 1'b0;
        end
        ctt_pkg::LX_INCLUDE: begin
          res_valid = 1'b1;
          if (in_byte == ctt_pkg::CH_GT) begin
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_INCLUDE;
          end else begin
            res.kind     = ctt_pkg::KIND_CHAR;
            res.char_out = in_byte;
          end
        end
        ctt_pkg::LX_QUOTED: begin
          res_valid = 1'b1;
          if (in_byte == ctt_pkg::CH_QUOTE) begin
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_QUOTED;
          end else begin
            res.kind     = ctt_pkg::KIND_CHAR;
            res.char_out = in_byte;
          end
        end
        ctt_pkg::LX_WORD: begin
          res_valid = 1'b1;
          if (c_word) begin
            res.kind     = ctt_pkg::KIND_CHAR;
            res.char_out = in_byte;
          end else if (!c_space) begin
            res.kind       = ctt_pkg::KIND_ERROR;
            res.error_code = ctt_pkg::ERR_UNEXPECTED;
          end else begin
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_WORD;
          end
        end
        ctt_pkg::LX_INT: begin
          res_valid = 1'b1;
          if (hex_ok || in_byte == ctt_pkg::CH_X || in_byte == ctt_pkg::CH_DOT) begin
            res.kind     = ctt_pkg::KIND_CHAR;
            res.char_out = in_byte;
          end else if (!c_space) begin
            res.kind       = ctt_pkg::KIND_ERROR;
            res.error_code = ctt_pkg::ERR_UNEXPECTED;
          end else if (int_bad) begin
            res.kind       = ctt_pkg::KIND_ERROR;
            res.error_code = ctt_pkg::ERR_BAD_INT;
          end else begin
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_INTEGER;
            res_value      = acc_r;
          end
        end
        ctt_pkg::LX_DEC: begin
          res_valid = 1'b1;
          if (c_digit || in_byte == ctt_pkg::CH_DOT) begin
            res.kind     = ctt_pkg::KIND_CHAR;
            res.char_out = in_byte;
          end else if (!c_space) begin
            res.kind       = ctt_pkg::KIND_ERROR;
            res.error_code = ctt_pkg::ERR_UNEXPECTED;
          end else if (dec_bad) begin
            res.kind       = ctt_pkg::KIND_ERROR;
            res.error_code = ctt_pkg::ERR_BAD_DEC;
          end else begin
            res.kind       = ctt_pkg::KIND_TOKEN_END;
            res.token_type = ctt_pkg::TT_DECIMAL;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ctt_pkg::LX_IDLE;
      base_r   <= ctt_pkg::BASE_DEC;
      flags_r  <= '0;
      acc_r    <= '0;
      line_r   <= POSITION_BITS'(1);
      col_r    <= '0;
      failed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      flags_r  <= flags_nxt;
      acc_r    <= acc_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/config_text_tokenizer_top.sv
// Top level of the config text tokenizer: input register, lexer and result register.
//
//   Channel | Ports  | tdata (low bit up)                                   | tuser / tlast
//   input   | in_*   | in_byte                                              | tlast: end_of_input
//   result  | out_*  | token_type, char_out, int_value, error_code,         | tuser: result_kind
//           |        | line_no, column_no, zero fill                        |
//
// One transaction is accepted per cycle unless the input stage stalls; an accepted byte
// waits in the input register, then its result is written to the result register.
// A synchronous active-low reset clears the lexer and sets the position to line 1, column 0.
// A held result stalls the input stage, and the input stage keeps accepting while the result
// register drains. Bytes that give no result leave the result register empty.
`timescale 1ns / 1ps
`default_nettype none
module config_text_tokenizer_top #(
  parameter int POSITION_BITS = ctt_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = ctt_pkg::VALUE_BITS_DEF,
  localparam int DATA_BITS    = 15 + VALUE_BITS - 1 + 2 * POSITION_BITS,
  localparam int OUT_TDATA_W  = ((DATA_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // in_byte
  input  wire logic                   in_tlast,   // end_of_input
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // token_type, char_out, int_value,
                                                  // error_code, line_no, column_no
  output logic      [1:0]             out_tuser   // result_kind
);

  logic                     s0_valid_r, s0_valid_nxt;
  logic [7:0]               s0_byte_r;
  logic                     s0_eoi_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic [1:0]               out_tuser_r;

  logic                     proceed;
  logic                     advance;
  logic                     in_fire;
  logic                     res_valid;
  ctt_pkg::res_t            res;
  logic [VALUE_BITS-2:0]    res_value;
  logic [POSITION_BITS-1:0] res_line;
  logic [POSITION_BITS-1:0] res_col;

  assign proceed   = !out_valid_r || out_tready;
  assign advance   = s0_valid_r && proceed;
  assign in_tready = !s0_valid_r || proceed;
  assign in_fire   = in_tvalid && in_tready;

  ctt_lexer #(
    .POSITION_BITS(POSITION_BITS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (advance),
    .in_byte     (s0_byte_r),
    .end_of_input(s0_eoi_r),
    .res_valid   (res_valid),
    .res         (res),
    .res_value   (res_value),
    .res_line    (res_line),
    .res_col     (res_col)
  );

  assign s0_valid_nxt  = in_fire || (s0_valid_r && !advance);
  assign out_valid_nxt = proceed ? (advance && res_valid) : out_valid_r;
  assign out_tdata_nxt = OUT_TDATA_W'({res_col, res_line, res.error_code, res_value,
                                       res.char_out, res.token_type});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_byte_r <= in_tdata;
      s0_eoi_r  <= in_tlast;
    end
    if (advance && res_valid) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= res.kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser == ctt_pkg::KIND_ERROR)
      |=> (!out_tvalid || out_tuser == ctt_pkg::KIND_ERROR))
    else $error("result after an error is not an error");
  a_type_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ctt_pkg::KIND_TOKEN_END) |-> (out_tdata[3:0] == 4'd0))
    else $error("token type set on a result that is not a token end");
  a_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == ctt_pkg::KIND_ERROR) ==
                    (out_tdata[VALUE_BITS+13:VALUE_BITS+11] != ctt_pkg::ERR_NONE)))
    else $error("error code does not match result kind");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");
`endif

endmodule
`default_nettype wire

FILE: sim/config_text_tokenizer_top_tb.sv
// Self-checking testbench that feeds text to the config text tokenizer and predicts each result.
`timescale 1ns / 1ps
`default_nettype none
module config_text_tokenizer_top_tb;
  import ctt_pkg::*;

  localparam int          TDATA_W     = 112;
  localparam logic [63:0] VALUE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] VALUE_MAX   = {63{1'b1}};
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [3:0]  AFTER_FAIL  = 4'd15;
  localparam int          HOLD_CYCLES = 400;
  localparam int          SAT_RUN     = 65540;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  ttype;
    logic [7:0]  ch;
    logic [62:0] ival;
    logic [2:0]  err;
    logic [15:0] line;
    logic [15:0] col;
  } lex_result_t;

  typedef struct packed {
    logic [3:0]  grp;
    logic [7:0]  b;
    logic        eoi;
    logic        typed;
    logic [1:0]  kind;
    logic [3:0]  ttype;
    logic [62:0] ival;
    logic [2:0]  err;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [29] = '{
    '{4'd0, CH_LBRACE,   1'b0, 1'b1, KIND_TOKEN_END, TT_LBRACE,   63'd0, ERR_NONE},
    '{4'd0, CH_RBRACE,   1'b0, 1'b1, KIND_TOKEN_END, TT_RBRACE,   63'd0, ERR_NONE},
    '{4'd0, CH_LBRACKET, 1'b0, 1'b1, KIND_TOKEN_END, TT_LBRACKET, 63'd0, ERR_NONE},
    '{4'd0, CH_RBRACKET, 1'b0, 1'b1, KIND_TOKEN_END, TT_RBRACKET, 63'd0, ERR_NONE},
    '{4'd0, CH_LPAREN,   1'b0, 1'b1, KIND_TOKEN_END, TT_LPAREN,   63'd0, ERR_NONE},
    '{4'd0, CH_RPAREN,   1'b0, 1'b1, KIND_TOKEN_END, TT_RPAREN,   63'd0, ERR_NONE},
    '{4'd0, "a",         1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, CH_UNDER,    1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, "9",         1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, 8'h20,       1'b0, 1'b1, KIND_TOKEN_END, TT_WORD,     63'd0, ERR_NONE},
    '{4'd0, CH_QUOTE,    1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, 8'h00,       1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, 8'hFF,       1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, CH_QUOTE,    1'b0, 1'b1, KIND_TOKEN_END, TT_QUOTED,   63'd0, ERR_NONE},
    '{4'd0, CH_LT,       1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, "f",         1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, CH_GT,       1'b0, 1'b1, KIND_TOKEN_END, TT_INCLUDE,  63'd0, ERR_NONE},
    '{4'd0, CH_ZERO,     1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, CH_SEVEN,    1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, 8'h09,       1'b0, 1'b1, KIND_TOKEN_END, TT_INTEGER,  63'd7, ERR_NONE},
    '{4'd0, CH_ZERO,     1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, CH_NL,       1'b0, 1'b1, KIND_TOKEN_END, TT_INTEGER,  63'd0, ERR_NONE},
    '{4'd0, CH_DOT,      1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, "5",         1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, 8'h0D,       1'b0, 1'b1, KIND_TOKEN_END, TT_DECIMAL,  63'd0, ERR_NONE},
    '{4'd0, CH_HASH,     1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, CH_RBRACE,   1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, CH_NL,       1'b0, 1'b0, KIND_CHAR,      TT_NONE,     63'd0, ERR_NONE},
    '{4'd0, 8'hFF,       1'b1, 1'b1, KIND_EOI,       TT_NONE,     63'd0, ERR_NONE}
  };

  // Only one failure can be seen per run, so one group is picked and then the tail follows.
  localparam stim_row_t FAIL_ROWS [24] = '{
    '{4'd1, "@",        1'b0, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_UNEXPECTED},
    '{4'd2, "a",        1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd2, "b",        1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd2, "$",        1'b0, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_UNEXPECTED},
    '{4'd3, CH_ZERO,    1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd3, CH_X,       1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd3, 8'h20,      1'b0, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_BAD_INT},
    '{4'd4, "1",        1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd4, "f",        1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd4, CH_NL,      1'b0, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_BAD_INT},
    '{4'd5, "1",        1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd5, CH_DOT,     1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd5, CH_DOT,     1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd5, "2",        1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd5, 8'h20,      1'b0, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_BAD_DEC},
    '{4'd6, CH_ZERO,    1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd6, CH_X,       1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd6, CH_DOT,     1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd6, 8'h09,      1'b0, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_BAD_DEC},
    '{4'd7, "5",        1'b0, 1'b0, KIND_CHAR,  TT_NONE, 63'd0, ERR_NONE},
    '{4'd7, CH_RBRACE,  1'b0, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_UNEXPECTED},
    '{AFTER_FAIL, "a",  1'b0, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_FAILED},
    '{AFTER_FAIL, CH_LBRACE, 1'b0, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_FAILED},
    '{AFTER_FAIL, 8'h00, 1'b1, 1'b1, KIND_ERROR, TT_NONE, 63'd0, ERR_FAILED}
  };

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic [7:0]         in_tdata   = 8'd0;
  logic               in_tlast   = 1'b0;
  logic               out_tready = 1'b0;
  logic               in_tready;
  logic               out_tvalid;
  logic [TDATA_W-1:0] out_tdata;
  logic [1:0]         out_tuser;

  logic calm        = 1'b0;
  logic hold_req    = 1'b0;
  logic hold_taken  = 1'b0;
  int   mismatches  = 0;

  lex_result_t pending [$];
  stim_row_t   text_q [$];

  lex_state_t  lx_state = LX_IDLE;
  logic [15:0] line_q   = 16'd1;
  logic [15:0] col_q    = 16'd0;
  logic [63:0] acc_q    = 64'd0;
  base_t       base_q   = BASE_DEC;
  logic [5:0]  flags_q  = 6'd0;
  logic        failed_q = 1'b0;

  config_text_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (is_num(c)) return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [63:0] scaled(input logic [63:0] acc, input logic [63:0] radix,
                                         input logic [63:0] d);
    if (acc > (VALUE_LIMIT - d) / radix) return VALUE_LIMIT;
    return acc * radix + d;
  endfunction

  function automatic lex_result_t at_pos(input logic [1:0] kind, input logic [3:0] ttype,
                                         input logic [7:0] ch, input logic [62:0] ival,
                                         input logic [2:0] err);
    lex_result_t r;
    r = '{kind, ttype, ch, ival, err, line_q, col_q};
    return r;
  endfunction

  task automatic echo(input logic [7:0] c, output logic hit, output lex_result_t r);
    hit = 1'b1;
    r = at_pos(KIND_CHAR, TT_NONE, c, 63'd0, ERR_NONE);
  endtask

  task automatic close_token(input logic [3:0] tt, input logic [62:0] v, output logic hit,
                             output lex_result_t r);
    lx_state = LX_IDLE;
    hit = 1'b1;
    r = at_pos(KIND_TOKEN_END, tt, 8'd0, v, ERR_NONE);
  endtask

  task automatic raise_error(input logic [2:0] e, output logic hit, output lex_result_t r);
    failed_q = 1'b1;
    lx_state = LX_IDLE;
    hit = 1'b1;
    r = at_pos(KIND_ERROR, TT_NONE, 8'd0, 63'd0, e);
  endtask

  task automatic take_int_char(input logic [7:0] c, input int hv);
    logic second;
    second = !flags_q[F_LONG];
    flags_q[F_LONG] = 1'b1;
    if (!is_num(c)) flags_q[F_NOTDEC] = 1'b1;
    if (!flags_q[F_BADINT]) begin
      case (base_q)
        BASE_DEC: begin
          if (is_num(c)) acc_q = scaled(acc_q, 64'd10, 64'(hv));
          else flags_q[F_BADINT] = 1'b1;
        end
        BASE_OCT: begin
          if (c == CH_X && second) base_q = BASE_HEX;
          else if (c >= CH_ZERO && c <= CH_SEVEN) acc_q = scaled(acc_q, 64'd8, 64'(hv));
          else flags_q[F_BADINT] = 1'b1;
        end
        default: begin
          if (hv >= 0) begin
            acc_q = scaled(acc_q, 64'd16, 64'(hv));
            flags_q[F_DIGIT] = 1'b1;
          end else begin
            flags_q[F_BADINT] = 1'b1;
          end
        end
      endcase
    end
  endtask

  // Advances the lexer by one accepted transaction and returns the result it gives, if any.
  task automatic lex_byte(input logic [7:0] c, input logic eoi, output logic hit,
                          output lex_result_t r);
    logic [5:0] f;
    int         hv;
    hit = 1'b1;
    r = '0;
    hv = hex_digit(c);
    if (failed_q) begin
      r = at_pos(KIND_ERROR, TT_NONE, 8'd0, 63'd0, ERR_FAILED);
      return;
    end
    if (eoi) begin
      lx_state = LX_IDLE;
      r = at_pos(KIND_EOI, TT_NONE, 8'd0, 63'd0, ERR_NONE);
      return;
    end
    if (col_q != POS_MAX) col_q = col_q + 16'd1;
    if (c == CH_NL) begin
      if (line_q != POS_MAX) line_q = line_q + 16'd1;
      col_q = 16'd0;
    end
    hit = 1'b0;
    case (lx_state)
      LX_IDLE: begin
        case (c)
          CH_LBRACE:   close_token(TT_LBRACE, 63'd0, hit, r);
          CH_RBRACE:   close_token(TT_RBRACE, 63'd0, hit, r);
          CH_LBRACKET: close_token(TT_LBRACKET, 63'd0, hit, r);
          CH_RBRACKET: close_token(TT_RBRACKET, 63'd0, hit, r);
          CH_LPAREN:   close_token(TT_LPAREN, 63'd0, hit, r);
          CH_RPAREN:   close_token(TT_RPAREN, 63'd0, hit, r);
          CH_QUOTE:    lx_state = LX_QUOTED;
          CH_HASH:     lx_state = LX_COMMENT;
          CH_LT:       lx_state = LX_INCLUDE;
          default: begin
            if (is_letter(c) || c == CH_UNDER) begin
              lx_state = LX_WORD;
              echo(c, hit, r);
            end else if (is_num(c)) begin
              lx_state = LX_INT;
              flags_q = 6'd0;
              base_q = (c == CH_ZERO) ? BASE_OCT : BASE_DEC;
              acc_q = 64'(c - CH_ZERO);
              echo(c, hit, r);
            end else if (c == CH_DOT) begin
              lx_state = LX_DEC;
              flags_q = 6'd0;
              flags_q[F_DOT] = 1'b1;
              acc_q = 64'd0;
              echo(c, hit, r);
            end else if (!is_blank(c)) begin
              raise_error(ERR_UNEXPECTED, hit, r);
            end
          end
        endcase
      end
      LX_COMMENT: begin
        if (c == CH_NL) lx_state = LX_IDLE;
      end
      LX_INCLUDE: begin
        if (c == CH_GT) close_token(TT_INCLUDE, 63'd0, hit, r);
        else echo(c, hit, r);
      end
      LX_QUOTED: begin
        if (c == CH_QUOTE) close_token(TT_QUOTED, 63'd0, hit, r);
        else echo(c, hit, r);
      end
      LX_WORD: begin
        if (is_letter(c) || is_num(c) || c == CH_UNDER) echo(c, hit, r);
        else if (!is_blank(c)) raise_error(ERR_UNEXPECTED, hit, r);
        else close_token(TT_WORD, 63'd0, hit, r);
      end
      LX_INT: begin
        if (hv >= 0 || c == CH_X) begin
          take_int_char(c, hv);
          echo(c, hit, r);
        end else if (c == CH_DOT) begin
          f = flags_q;
          if (!f[F_NOTDEC]) flags_q = 6'd1 << F_DIGIT;
          else if (base_q == BASE_HEX && !f[F_BADINT]) flags_q = f & (6'd1 << F_DIGIT);
          else flags_q = 6'd1 << F_BADDEC;
          flags_q[F_DOT] = 1'b1;
          lx_state = LX_DEC;
          echo(c, hit, r);
        end else if (!is_blank(c)) begin
          raise_error(ERR_UNEXPECTED, hit, r);
        end else if (flags_q[F_BADINT] || (base_q == BASE_HEX && !flags_q[F_DIGIT])) begin
          raise_error(ERR_BAD_INT, hit, r);
        end else begin
          close_token(TT_INTEGER, acc_q[62:0], hit, r);
        end
      end
      LX_DEC: begin
        if (is_num(c)) begin
          flags_q[F_DIGIT] = 1'b1;
          echo(c, hit, r);
        end else if (c == CH_DOT) begin
          if (flags_q[F_DOT]) flags_q[F_BADDEC] = 1'b1;
          flags_q[F_DOT] = 1'b1;
          echo(c, hit, r);
        end else if (!is_blank(c)) begin
          raise_error(ERR_UNEXPECTED, hit, r);
        end else if (flags_q[F_BADDEC] || !flags_q[F_DIGIT]) begin
          raise_error(ERR_BAD_DEC, hit, r);
        end else begin
          close_token(TT_DECIMAL, 63'd0, hit, r);
        end
      end
      default: lx_state = LX_IDLE;
    endcase
  endtask

  function automatic stim_row_t plain(input logic [7:0] b);
    stim_row_t s;
    s = '0;
    s.b = b;
    return s;
  endfunction

  function automatic stim_row_t end_row(input logic [7:0] b);
    stim_row_t s;
    s = plain(b);
    s.eoi = 1'b1;
    return s;
  endfunction

  function automatic logic [7:0] rand_letter();
    int n;
    n = $urandom_range(52);
    if (n < 26) return "a" + n;
    if (n < 52) return "A" + (n - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_blank();
    logic [7:0] ws [6];
    ws = '{8'h20, 8'h09, CH_NL, 8'h0B, 8'h0C, 8'h0D};
    return ws[$urandom_range(5)];
  endfunction

  function automatic logic [7:0] rand_hex();
    int n;
    n = $urandom_range(21);
    if (n < 10) return "0" + n;
    if (n < 16) return "a" + (n - 10);
    return "A" + (n - 16);
  endfunction

  function automatic logic [7:0] rand_dig(input int top);
    return "0" + $urandom_range(top);
  endfunction

  function automatic logic [7:0] rand_except(input logic [7:0] stop);
    logic [7:0] b;
    do b = $urandom_range(255); while (b == stop);
    return b;
  endfunction

  // Appends one well-formed token, comment or run of blanks, or text cut short by end of input, to the text queue.
  task automatic add_phrase();
    logic [7:0] brackets [6];
    int         n;
    int         form;
    brackets = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_LPAREN, CH_RPAREN};
    case ($urandom_range(19))
      0, 1: text_q.push_back(plain(brackets[$urandom_range(5)]));
      2, 3, 4: begin
        text_q.push_back(plain(rand_letter()));
        repeat ($urandom_range(8))
          text_q.push_back(plain($urandom_range(2) == 0 ? rand_dig(9) : rand_letter()));
        text_q.push_back(plain(rand_blank()));
      end
      5, 6: begin
        text_q.push_back(plain(CH_QUOTE));
        repeat ($urandom_range(10)) text_q.push_back(plain(rand_except(CH_QUOTE)));
        text_q.push_back(plain(CH_QUOTE));
      end
      7: begin
        text_q.push_back(plain(CH_LT));
        repeat ($urandom_range(8)) text_q.push_back(plain(rand_except(CH_GT)));
        text_q.push_back(plain(CH_GT));
      end
      8: begin
        text_q.push_back(plain(CH_HASH));
        repeat ($urandom_range(8)) text_q.push_back(plain(rand_except(CH_NL)));
        if ($urandom_range(3) == 0) text_q.push_back(end_row($urandom_range(255)));
        else text_q.push_back(plain(CH_NL));
      end
      9, 10: begin
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 21) : $urandom_range(7);
        text_q.push_back(plain("1" + $urandom_range(8)));
        repeat (n) text_q.push_back(plain(rand_dig(9)));
        text_q.push_back(plain(rand_blank()));
      end
      11: begin
        n = ($urandom_range(9) == 0) ? 22 : $urandom_range(8);
        text_q.push_back(plain(CH_ZERO));
        repeat (n) text_q.push_back(plain(rand_dig(7)));
        text_q.push_back(plain(rand_blank()));
      end
      12, 13: begin
        text_q.push_back(plain(CH_ZERO));
        text_q.push_back(plain(CH_X));
        form = $urandom_range(9);
        if (form == 0) begin
          text_q.push_back(plain(CH_SEVEN));
          repeat (15) text_q.push_back(plain("f"));
        end else if (form == 1) begin
          repeat (17) text_q.push_back(plain("F"));
        end else begin
          repeat ($urandom_range(1, 8)) text_q.push_back(plain(rand_hex()));
        end
        text_q.push_back(plain(rand_blank()));
      end
      14, 15: begin
        form = $urandom_range(3);
        if (form == 0 || form == 3) begin
          repeat ($urandom_range(1, 4)) text_q.push_back(plain(rand_dig(9)));
        end else if (form == 2) begin
          text_q.push_back(plain(CH_ZERO));
          text_q.push_back(plain(CH_X));
          repeat ($urandom_range(1, 3)) text_q.push_back(plain(rand_hex()));
        end
        text_q.push_back(plain(CH_DOT));
        n = (form == 1) ? $urandom_range(1, 4) : (form == 3) ? 0 : $urandom_range(3);
        repeat (n) text_q.push_back(plain(rand_dig(9)));
        text_q.push_back(plain(rand_blank()));
      end
      16: repeat ($urandom_range(1, 4)) text_q.push_back(plain(rand_blank()));
      17: text_q.push_back(end_row($urandom_range(255)));
      18: begin
        form = $urandom_range(2);
        if (form == 0) text_q.push_back(plain(rand_letter()));
        else if (form == 1) text_q.push_back(plain(rand_dig(9)));
        else text_q.push_back(plain(CH_LT));
        text_q.push_back(plain(rand_dig(9)));
        text_q.push_back(end_row($urandom_range(255)));
      end
      default: begin
        text_q.push_back(plain(CH_QUOTE));
        repeat ($urandom_range(1, 12)) text_q.push_back(plain(rand_except(CH_QUOTE)));
        text_q.push_back(end_row($urandom_range(255)));
      end
    endcase
  endtask

  // Starts and ends on a rising edge; the transaction is accepted at the edge it returns on.
  task automatic offer(input stim_row_t row);
    int          gap;
    logic        hit;
    lex_result_t r;
    gap = 0;
    if (!calm && $urandom_range(99) < 7) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= row.b;
    in_tlast <= row.eoi;
    do @(posedge clk); while (!in_tready);
    lex_byte(row.b, row.eoi, hit, r);
    if (row.typed) begin
      r.kind = row.kind;
      r.ttype = row.ttype;
      r.ch = 8'd0;
      r.ival = row.ival;
      r.err = row.err;
      hit = 1'b1;
    end
    if (hit) pending.push_back(r);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        out_tready <= 1'b0;
        left--;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  function automatic string field_diff(input lex_result_t w, input lex_result_t g);
    string s;
    s = "";
    if (w.kind !== g.kind) s = {s, " kind"};
    if (w.ttype !== g.ttype) s = {s, " token_type"};
    if (w.ch !== g.ch) s = {s, " char"};
    if (w.ival !== g.ival) s = {s, " value"};
    if (w.err !== g.err) s = {s, " error"};
    if (w.line !== g.line) s = {s, " line"};
    if (w.col !== g.col) s = {s, " column"};
    return s;
  endfunction

  always @(posedge clk) begin
    lex_result_t got;
    lex_result_t want;
    string       diff;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[3:0], out_tdata[11:4], out_tdata[74:12],
              out_tdata[77:75], out_tdata[93:78], out_tdata[109:94]};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: transaction with no result pending: kind=%0d type=%0d char=%02h",
                   $realtime, got.kind, got.ttype, got.ch);
      end else begin
        want = pending.pop_front();
        diff = field_diff(want, got);
        if (diff != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: wrong%s", $realtime, diff);
            $display("  expected kind=%0d type=%0d char=%02h value=%0d err=%0d line=%0d col=%0d",
                     want.kind, want.ttype, want.ch, want.ival, want.err, want.line, want.col);
            $display("  actual   kind=%0d type=%0d char=%02h value=%0d err=%0d line=%0d col=%0d",
                     got.kind, got.ttype, got.ch, got.ival, got.err, got.line, got.col);
          end
        end
      end
    end
  end

  initial begin
    int sent;
    int pick;
    int w;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[i]) offer(DIRECTED_ROWS[i]);
    wait_drained();
    while (sent < 650) begin
      calm = (sent >= 150 && sent < 300);
      if (sent >= 400) hold_req = 1'b1;
      if (sent >= 500 && sent < 520) begin
        wait_drained();
        sent = 520;
      end
      add_phrase();
      while (text_q.size() != 0) begin
        offer(text_q.pop_front());
        sent++;
      end
    end
    calm = 1'b0;
    // Saturate the column, then the line, and check each with a bracket.
    repeat (SAT_RUN) offer(plain(8'h20));
    offer(plain(CH_LBRACE));
    repeat (SAT_RUN) offer(plain(CH_NL));
    offer(plain(CH_RBRACE));
    offer(end_row(8'h00));
    pick = $urandom_range(1, 7);
    foreach (FAIL_ROWS[i])
      if (FAIL_ROWS[i].grp == pick || FAIL_ROWS[i].grp == AFTER_FAIL) offer(FAIL_ROWS[i]);
    in_tvalid <= 1'b0;
    for (w = 0; w < 200000 && pending.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
design/ctt_pkg.sv
design/ctt_acc.sv
design/ctt_lexer.sv
design/config_text_tokenizer_top.sv
sim/config_text_tokenizer_top_tb.sv
